// ===== design/smx_pkg.sv =====
`default_nettype none

package smx_pkg;

  // Store depth and the widths that follow from it.
  localparam int MAX_SET_SIZE = 16;
  localparam int ADDR_W       = $clog2(MAX_SET_SIZE);
  localparam int COUNT_W      = $clog2(MAX_SET_SIZE + 1);
  localparam int INDEX_W      = 4;
  localparam int EXP_W        = 17;
  localparam int SUM_W        = EXP_W + $clog2(MAX_SET_SIZE);
  localparam int QUOT_W       = 17;
  localparam int DIV_STEPS_W  = $clog2(QUOT_W + 1);

  // Differences larger than eleven units give an exponential of zero.
  localparam logic [15:0] EXP_LIMIT = 16'd2816;
  localparam logic signed [15:0] LOGIT_MIN = 16'sh8000;

  // One input item: a Q8.8 logit and the end-of-set flag.
  typedef struct packed {
    logic signed [15:0] logit;
    logic               last_option;
  } smx_logit_t;

  // One result item.
  typedef struct packed {
    logic [15:0]        probability;
    logic [INDEX_W-1:0] option_index;
    logic               final_result;
    logic               overflowed;
  } smx_prob_t;

  // Top-level sequencer states.
  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_EXP_READ,
    ST_EXP_START,
    ST_EXP_WAIT,
    ST_DIV_READ,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_EMIT
  } smx_state_t;

  // Exponential unit states.
  typedef enum logic [1:0] {
    EXP_IDLE,
    EXP_MUL,
    EXP_RND,
    EXP_DONE
  } smx_exp_state_t;

  // Divider states.
  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } smx_div_state_t;

  // Alternating Taylor series of exp(-x/256) in Q0.31, seventeen terms.
  function automatic logic [31:0] exp_frac(input logic [8:0] x);
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    int          k;
    term = 64'd1 << 31;
    pos  = term;
    neg  = 64'd0;
    for (k = 1; k <= 16; k++) begin
      term = (term * 64'(x)) / 64'(256 * k);
      if ((k % 2) == 1) begin
        neg = neg + term;
      end else begin
        pos = pos + term;
      end
    end
    return 32'(pos - neg);
  endfunction

  // Table of exp(-b/256) for the fractional part b of a difference.
  function automatic logic [255:0][31:0] build_exp_lut();
    logic [255:0][31:0] lut;
    int                 i;
    for (i = 0; i < 256; i++) begin
      lut[i] = exp_frac(9'(i));
    end
    return lut;
  endfunction

  localparam logic [255:0][31:0] EXP_FRAC_LUT = build_exp_lut();
  localparam logic [31:0]        EXP_ONE_UNIT = exp_frac(9'd256);

endpackage

`default_nettype wire

// ===== design/smx_exp_unit.sv =====
`default_nettype none

module smx_exp_unit import smx_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [15:0]            diff,
  output logic                   done,
  output logic [EXP_W-1:0]       result
);

  smx_exp_state_t state;
  smx_exp_state_t state_next;

  logic [3:0]  steps;
  logic [31:0] value;
  logic [63:0] prod;
  logic [63:0] prod_rnd;
  logic [32:0] value_rnd;
  logic        in_range;

  assign in_range  = (diff <= EXP_LIMIT);
  assign prod_rnd  = prod + (64'd1 << 30);
  assign value_rnd = {1'b0, value} + (33'd1 << 14);

  // The result is shown while the unit sits in its done state.
  assign done   = (state == EXP_DONE);
  assign result = value_rnd[31:15];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= EXP_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Whole units of the difference each cost one multiply and one round.
  always_comb begin
    state_next = state;
    case (state)
      EXP_IDLE: begin
        if (start) begin
          if (in_range && (diff[11:8] != 4'd0)) begin
            state_next = EXP_MUL;
          end else begin
            state_next = EXP_DONE;
          end
        end
      end
      EXP_MUL: begin
        state_next = EXP_RND;
      end
      EXP_RND: begin
        if (steps == 4'd1) begin
          state_next = EXP_DONE;
        end else begin
          state_next = EXP_MUL;
        end
      end
      EXP_DONE: begin
        state_next = EXP_IDLE;
      end
      default: begin
        state_next = EXP_IDLE;
      end
    endcase
  end

  // Shared multiplier: value times exp(-1), then rounding back to Q0.31.
  always_ff @(posedge clk) begin
    case (state)
      EXP_IDLE: begin
        if (start) begin
          steps <= diff[11:8];
          if (in_range) begin
            value <= EXP_FRAC_LUT[diff[7:0]];
          end else begin
            value <= 32'd0;
          end
        end
      end
      EXP_MUL: begin
        prod <= 64'(value) * 64'(EXP_ONE_UNIT);
      end
      EXP_RND: begin
        value <= prod_rnd[62:31];
        steps <= steps - 4'd1;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/smx_div_unit.sv =====
`default_nettype none

module smx_div_unit import smx_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [EXP_W-1:0]   numer,
  input  logic [SUM_W-1:0]   denom,
  output logic               done,
  output logic [15:0]        quotient
);

  smx_div_state_t state;
  smx_div_state_t state_next;

  logic [DIV_STEPS_W-1:0] steps;
  logic [SUM_W-1:0]       rem;
  logic [SUM_W-1:0]       divisor;
  logic [QUOT_W-1:0]      quot;
  logic [SUM_W:0]         cand;
  logic                   fits;

  // The first step compares the numerator itself; later steps shift left.
  assign cand = (steps == '0) ? {1'b0, rem} : {rem, 1'b0};
  assign fits = (cand >= {1'b0, divisor});

  // A quotient of one or more saturates just below one.
  assign done     = (state == DIV_DONE);
  assign quotient = quot[QUOT_W-1] ? 16'hFFFF : quot[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DIV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      DIV_IDLE: begin
        if (start) begin
          state_next = DIV_RUN;
        end
      end
      DIV_RUN: begin
        if (steps == DIV_STEPS_W'(QUOT_W - 1)) begin
          state_next = DIV_DONE;
        end
      end
      DIV_DONE: begin
        state_next = DIV_IDLE;
      end
      default: begin
        state_next = DIV_IDLE;
      end
    endcase
  end

  // Restoring division, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    case (state)
      DIV_IDLE: begin
        if (start) begin
          rem     <= SUM_W'(numer);
          divisor <= denom;
          quot    <= '0;
          steps   <= '0;
        end
      end
      DIV_RUN: begin
        if (fits) begin
          rem <= SUM_W'(cand - {1'b0, divisor});
        end else begin
          rem <= SUM_W'(cand);
        end
        quot  <= {quot[QUOT_W-2:0], fits};
        steps <= steps + DIV_STEPS_W'(1);
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/softmax_probabilities.sv =====
`default_nettype none

// Softmax over a set of signed Q8.8 logits, one logit per item, with the last
// item of a set flagged. Logits are accepted as they arrive while the block
// collects; up to MAX_SET_SIZE are stored and later ones are dropped and
// reported on every result of that set. After the final logit the block stops
// taking items and works through the set twice with its two shared units: for
// each option the exponential unit does one multiply and one rounding step per
// whole unit of (max - logit), 0 to 11 units within the cutoff, and none
// beyond it; then each probability comes from a bit-serial divider and is
// offered and taken before the next divide starts. Results leave in arrival
// order from an output register, and the block takes logits again in the
// cycle after the last result of the set is taken.
module softmax_probabilities import smx_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       logit_valid,
  output logic       logit_ready,
  input  smx_logit_t logit_item,
  output logic       prob_valid,
  input  logic       prob_ready,
  output smx_prob_t  prob_item
);

  smx_state_t state;
  smx_state_t state_next;

  logic [EXP_W-1:0]  exp_store [MAX_SET_SIZE];
  logic signed [15:0] logit_store [MAX_SET_SIZE];

  logic [COUNT_W-1:0] option_count;
  logic signed [15:0] running_max;
  logic [SUM_W-1:0]   exp_sum;
  logic               overflow_flag;
  logic [ADDR_W-1:0]  k;

  logic signed [15:0] logit_rd;
  logic [EXP_W-1:0]   exp_rd;

  logic               logit_take;
  logic               store_full;
  logic               k_is_last;
  logic signed [16:0] diff_wide;
  logic [15:0]        diff;

  logic               exp_start;
  logic               exp_done;
  logic [EXP_W-1:0]   exp_result;
  logic               div_start;
  logic               div_done;
  logic [15:0]        div_quotient;

  assign logit_take = logit_valid && logit_ready;
  assign store_full = (option_count == COUNT_W'(MAX_SET_SIZE));
  assign k_is_last  = ((COUNT_W'(k) + COUNT_W'(1)) == option_count);
  assign diff_wide  = {running_max[15], running_max} - {logit_rd[15], logit_rd};
  assign diff       = diff_wide[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_COLLECT;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: collect, exponentials for every option, then one divide each.
  always_comb begin
    state_next  = state;
    logit_ready = 1'b0;
    prob_valid  = 1'b0;
    exp_start   = 1'b0;
    div_start   = 1'b0;
    case (state)
      ST_COLLECT: begin
        logit_ready = 1'b1;
        if (logit_valid && logit_item.last_option) begin
          state_next = ST_EXP_READ;
        end
      end
      ST_EXP_READ: begin
        state_next = ST_EXP_START;
      end
      ST_EXP_START: begin
        exp_start  = 1'b1;
        state_next = ST_EXP_WAIT;
      end
      ST_EXP_WAIT: begin
        if (exp_done) begin
          state_next = k_is_last ? ST_DIV_READ : ST_EXP_READ;
        end
      end
      ST_DIV_READ: begin
        state_next = ST_DIV_START;
      end
      ST_DIV_START: begin
        div_start  = 1'b1;
        state_next = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        prob_valid = 1'b1;
        if (prob_ready) begin
          state_next = prob_item.final_result ? ST_COLLECT : ST_DIV_READ;
        end
      end
      default: begin
        state_next = ST_COLLECT;
      end
    endcase
  end

  // Set bookkeeping: count, maximum, overflow, sum and the option pointer.
  always_ff @(posedge clk) begin
    if (rst) begin
      option_count  <= '0;
      running_max   <= LOGIT_MIN;
      exp_sum       <= '0;
      overflow_flag <= 1'b0;
      k             <= '0;
    end else begin
      case (state)
        ST_COLLECT: begin
          if (logit_take) begin
            if (store_full) begin
              overflow_flag <= 1'b1;
            end else begin
              option_count <= option_count + COUNT_W'(1);
              if (logit_item.logit > running_max) begin
                running_max <= logit_item.logit;
              end
            end
            k       <= '0;
            exp_sum <= '0;
          end
        end
        ST_EXP_WAIT: begin
          if (exp_done) begin
            exp_sum <= exp_sum + SUM_W'(exp_result);
            k       <= k_is_last ? '0 : k + ADDR_W'(1);
          end
        end
        ST_EMIT: begin
          if (prob_ready) begin
            if (prob_item.final_result) begin
              option_count  <= '0;
              running_max   <= LOGIT_MIN;
              exp_sum       <= '0;
              overflow_flag <= 1'b0;
              k             <= '0;
            end else begin
              k <= k + ADDR_W'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Logit store: written on arrival, read once per option.
  always_ff @(posedge clk) begin
    if ((state == ST_COLLECT) && logit_take && !store_full) begin
      logit_store[option_count[ADDR_W-1:0]] <= logit_item.logit;
    end
    if (state == ST_EXP_READ) begin
      logit_rd <= logit_store[k];
    end
  end

  // Exponential store: written as each term is done, read for the divides.
  always_ff @(posedge clk) begin
    if ((state == ST_EXP_WAIT) && exp_done) begin
      exp_store[k] <= exp_result;
    end
    if (state == ST_DIV_READ) begin
      exp_rd <= exp_store[k];
    end
  end

  // Output register holds the result item until it is taken.
  always_ff @(posedge clk) begin
    if ((state == ST_DIV_WAIT) && div_done) begin
      prob_item.probability  <= div_quotient;
      prob_item.option_index <= INDEX_W'(k);
      prob_item.final_result <= k_is_last;
      prob_item.overflowed   <= overflow_flag;
    end
  end

  smx_exp_unit u_exp (
    .clk    (clk),
    .rst    (rst),
    .start  (exp_start),
    .diff   (diff),
    .done   (exp_done),
    .result (exp_result)
  );

  smx_div_unit u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .numer    (exp_rd),
    .denom    (exp_sum),
    .done     (div_done),
    .quotient (div_quotient)
  );

endmodule

`default_nettype wire

// ===== design/smx_checker.sv =====
`default_nettype none

module smx_checker import smx_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       logit_valid,
  input logic       logit_ready,
  input smx_logit_t logit_item,
  input logic       prob_valid,
  input logic       prob_ready,
  input smx_prob_t  prob_item
);

  // A result waiting to be taken holds its value.
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    prob_valid && !prob_ready |=> prob_valid && $stable(prob_item))
    else $error("result item changed while stalled");

  // The block never takes logits while results of a set are pending.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(logit_ready && prob_valid))
    else $error("logit taken while a result is pending");

  // Closing a set stops further logits until the results are out.
  a_set_closes: assert property (@(posedge clk) disable iff (rst)
    logit_valid && logit_ready && logit_item.last_option |=> !logit_ready)
    else $error("logit accepted right after the end of a set");

  // After the final result the block is back to collecting.
  a_set_reopens: assert property (@(posedge clk) disable iff (rst)
    prob_valid && prob_ready && prob_item.final_result |=> logit_ready && !prob_valid)
    else $error("block did not return to collecting after the final result");

  // Before the final result the block keeps working on the same set.
  a_set_continues: assert property (@(posedge clk) disable iff (rst)
    prob_valid && prob_ready && !prob_item.final_result |=> !logit_ready)
    else $error("logit accepted before the final result of a set");

endmodule

bind softmax_probabilities smx_checker u_smx_checker (.*);

`default_nettype wire
